@@ rtl/lrms_pkg.sv @@
package lrms_pkg;

   localparam int unsigned CODE_W  = 8;
   localparam int unsigned MS_W    = 10;
   localparam int unsigned SPEED_W = 4;
   localparam int unsigned CSR_W   = 2;

   localparam int unsigned FLASH_MS_DEFAULT     = 20;
   localparam int unsigned OFF_PULSE_MS_DEFAULT = 10;

   // item kinds
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_CMD  = 1'b1;

   // configuration register indexes
   localparam logic [CSR_W-1:0] CSR_CODE_OFF    = 2'd0;
   localparam logic [CSR_W-1:0] CSR_CODE_EFFECT = 2'd1;
   localparam logic [CSR_W-1:0] CSR_CODE_COLOUR = 2'd2;
   localparam logic [CSR_W-1:0] CSR_CODE_MAIN   = 2'd3;

   localparam logic [CODE_W-1:0] CODE_OFF_RST    = 8'h72;
   localparam logic [CODE_W-1:0] CODE_EFFECT_RST = 8'h71;
   localparam logic [CODE_W-1:0] CODE_COLOUR_RST = 8'h63;
   localparam logic [CODE_W-1:0] CODE_MAIN_RST   = 8'h61;

   // effect numbers
   localparam logic [2:0] EFF_NONE    = 3'd0;
   localparam logic [2:0] EFF_BLINK   = 3'd1;
   localparam logic [2:0] EFF_COUNT   = 3'd2;
   localparam logic [2:0] EFF_TOGGLE  = 3'd3;
   localparam logic [2:0] EFF_BOTH    = 3'd4;
   localparam logic [2:0] EFF_FL_RGB  = 3'd5;
   localparam logic [2:0] EFF_FL_MAIN = 3'd6;
   localparam logic [2:0] EFF_FL_ALL  = 3'd7;

   localparam logic [SPEED_W-1:0] SPEED_MAX = 4'd9;
   localparam logic [SPEED_W-1:0] SPEED_RST = 4'd5;

   // colour bits: red, green, blue
   localparam logic [2:0] RGB_OFF   = 3'b000;
   localparam logic [2:0] RGB_RED   = 3'b100;
   localparam logic [2:0] RGB_GREEN = 3'b010;
   localparam logic [2:0] RGB_BLUE  = 3'b001;
   localparam logic [2:0] RGB_ALL   = 3'b111;

   function automatic logic [MS_W-1:0] delay_ms(input logic [SPEED_W-1:0] idx);
      logic [MS_W-1:0] d;
      unique case (idx)
         4'd0:    d = 10'd20;
         4'd1:    d = 10'd25;
         4'd2:    d = 10'd50;
         4'd3:    d = 10'd100;
         4'd4:    d = 10'd200;
         4'd5:    d = 10'd300;
         4'd6:    d = 10'd400;
         4'd7:    d = 10'd500;
         4'd8:    d = 10'd800;
         default: d = 10'd1000;
      endcase
      return d;
   endfunction

endpackage

@@ rtl/lamp_remote_mode_sequencer_core.sv @@
// Lamp remote sequencer: drives an RGB strip and a main light from decoded remote
// command bytes (req_op = 1) and one-millisecond ticks (req_op = 0). Every accepted
// item returns one response with the four drive levels after that item. The block
// takes one item per clock as long as the response side keeps up: an input register
// feeds a single pass of next-state logic that updates the mode state and the
// response register. Command codes are programmable through the csr_ port (index 0
// off, 1 effect, 2 colour, 3 main); write them only while no item is in flight.
module lamp_remote_mode_sequencer_core #(
   parameter int unsigned FLASH_MS     = lrms_pkg::FLASH_MS_DEFAULT,
   parameter int unsigned OFF_PULSE_MS = lrms_pkg::OFF_PULSE_MS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_op,
   input  logic [lrms_pkg::CODE_W-1:0]  req_cmd_code,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_led_red,
   output logic                         rsp_led_green,
   output logic                         rsp_led_blue,
   output logic                         rsp_main_light,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lrms_pkg::CSR_W-1:0]   csr_index,
   input  logic [lrms_pkg::CODE_W-1:0]  csr_wdata
);
   import lrms_pkg::*;

   typedef struct packed {
      logic [2:0]      colour;
      logic            light;
      logic [MS_W-1:0] ms;
   } step_type;

   localparam logic [MS_W-1:0] FLASH_LEN = MS_W'(FLASH_MS);
   localparam logic [MS_W-1:0] PULSE_LEN = MS_W'(OFF_PULSE_MS);

   // action of one effect step and the wait it loads
   function automatic step_type effect_step(input logic [2:0] eff,
                                            input logic first,
                                            input logic [2:0] colour,
                                            input logic light,
                                            input logic [SPEED_W-1:0] speed);
      step_type        s;
      logic [2:0]      cnt;
      logic [MS_W-1:0] d;
      d        = delay_ms(speed);
      cnt      = (colour == RGB_ALL) ? 3'd1 : colour + 3'd1;
      s.colour = colour;
      s.light  = light;
      s.ms     = d;
      unique case (eff)
         EFF_BLINK:  s.colour = first ? RGB_ALL : RGB_OFF;
         EFF_COUNT:  s.colour = cnt;
         EFF_TOGGLE: s.light = ~light;
         EFF_BOTH: begin
            s.light  = ~light;
            s.colour = cnt;
         end
         EFF_FL_RGB: begin
            s.colour = first ? RGB_ALL : RGB_OFF;
            s.ms     = first ? FLASH_LEN : d;
         end
         EFF_FL_MAIN: begin
            s.light = first;
            s.ms    = first ? FLASH_LEN : d;
         end
         EFF_FL_ALL: begin
            s.colour = first ? RGB_ALL : RGB_OFF;
            s.light  = first;
            s.ms     = first ? FLASH_LEN : d;
         end
         default: s.ms = '0;
      endcase
      return s;
   endfunction

   logic [CODE_W-1:0]  code_off_ff, code_effect_ff, code_colour_ff, code_main_ff;
   logic               in_valid_ff;
   logic               in_op_ff;
   logic [CODE_W-1:0]  in_cmd_ff;
   logic               rsp_valid_ff;
   logic               advance;

   logic [1:0]         main_mode_ff, main_mode_in;
   logic [2:0]         colour_mode_ff, colour_mode_in;
   logic [2:0]         effect_mode_ff, effect_mode_in;
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic [2:0]         colour_out_ff, colour_out_in;
   logic               light_out_ff, light_out_in;
   logic [MS_W-1:0]    ms_left_ff, ms_left_in;
   logic               phase_ff, phase_in;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_led_red    = colour_out_ff[2];
   assign rsp_led_green  = colour_out_ff[1];
   assign rsp_led_blue   = colour_out_ff[0];
   assign rsp_main_light = light_out_ff;

   always_comb begin
      step_type        s;
      logic [MS_W-1:0] ms_dec;
      logic            ph;
      main_mode_in   = main_mode_ff;
      colour_mode_in = colour_mode_ff;
      effect_mode_in = effect_mode_ff;
      speed_in       = speed_ff;
      colour_out_in  = colour_out_ff;
      light_out_in   = light_out_ff;
      ms_left_in     = ms_left_ff;
      phase_in       = phase_ff;
      ms_dec         = ms_left_ff - MS_W'(1);
      s              = '0;
      ph             = phase_ff;
      priority if (in_op_ff == OP_TICK) begin
         if (ms_left_ff != '0) begin
            ms_left_in = ms_dec;
            if (ms_dec == '0) begin
               if (effect_mode_ff != EFF_NONE) begin
                  // two-phase effects alternate on and off steps
                  if (effect_mode_ff == EFF_BLINK || effect_mode_ff >= EFF_FL_RGB)
                     ph = ~phase_ff;
                  s = effect_step(effect_mode_ff, !ph, colour_out_ff, light_out_ff,
                                  speed_ff);
                  phase_in      = ph;
                  colour_out_in = s.colour;
                  light_out_in  = s.light;
                  ms_left_in    = s.ms;
               end else begin
                  light_out_in = (main_mode_ff != 2'd0);
               end
            end
         end
      end else if (in_cmd_ff == code_off_ff) begin
         main_mode_in   = '0;
         colour_mode_in = '0;
         effect_mode_in = EFF_NONE;
         speed_in       = '0;
         colour_out_in  = RGB_OFF;
         light_out_in   = 1'b0;
         ms_left_in     = '0;
         phase_in       = 1'b0;
      end else if (in_cmd_ff == code_effect_ff) begin
         main_mode_in   = '0;
         colour_mode_in = '0;
         effect_mode_in = effect_mode_ff + 3'd1;
         phase_in       = 1'b0;
         s = effect_step(effect_mode_ff + 3'd1, 1'b1, RGB_OFF, 1'b0, speed_ff);
         colour_out_in  = s.colour;
         light_out_in   = s.light;
         ms_left_in     = s.ms;
      end else if (in_cmd_ff == code_colour_ff) begin
         if (effect_mode_ff != EFF_NONE) begin
            if (speed_ff != '0) speed_in = speed_ff - SPEED_W'(1);
         end else begin
            colour_mode_in = (colour_mode_ff < 3'd4) ? colour_mode_ff + 3'd1 : 3'd0;
            unique case (colour_mode_in)
               3'd1:    colour_out_in = RGB_RED;
               3'd2:    colour_out_in = RGB_GREEN;
               3'd3:    colour_out_in = RGB_BLUE;
               3'd4:    colour_out_in = RGB_ALL;
               default: colour_out_in = RGB_OFF;
            endcase
         end
      end else if (in_cmd_ff == code_main_ff) begin
         if (effect_mode_ff != EFF_NONE) begin
            if (speed_ff < SPEED_MAX) speed_in = speed_ff + SPEED_W'(1);
         end else begin
            main_mode_in = main_mode_ff + 2'd1;
            light_out_in = 1'b0;
            ms_left_in   = PULSE_LEN;
         end
      end else begin
         // unknown code, state holds
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_off_ff    <= CODE_OFF_RST;
         code_effect_ff <= CODE_EFFECT_RST;
         code_colour_ff <= CODE_COLOUR_RST;
         code_main_ff   <= CODE_MAIN_RST;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         main_mode_ff   <= 2'd1;
         colour_mode_ff <= '0;
         effect_mode_ff <= EFF_NONE;
         speed_ff       <= SPEED_RST;
         colour_out_ff  <= RGB_OFF;
         light_out_ff   <= 1'b1;
         ms_left_ff     <= '0;
         phase_ff       <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_CODE_OFF:    code_off_ff    <= csr_wdata;
               CSR_CODE_EFFECT: code_effect_ff <= csr_wdata;
               CSR_CODE_COLOUR: code_colour_ff <= csr_wdata;
               CSR_CODE_MAIN:   code_main_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (req_ready) in_valid_ff <= req_valid;
         if (advance) begin
            rsp_valid_ff   <= 1'b1;
            main_mode_ff   <= main_mode_in;
            colour_mode_ff <= colour_mode_in;
            effect_mode_ff <= effect_mode_in;
            speed_ff       <= speed_in;
            colour_out_ff  <= colour_out_in;
            light_out_ff   <= light_out_in;
            ms_left_ff     <= ms_left_in;
            phase_ff       <= phase_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // input payload needs no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff  <= req_op;
         in_cmd_ff <= req_cmd_code;
      end
   end

`ifndef SYNTH
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      speed_ff <= SPEED_MAX)
      else $error("speed index out of range");

   a_colour_mode_range: assert property (@(posedge clock) disable iff (reset)
      colour_mode_ff <= 3'd4)
      else $error("colour mode out of range");

   a_effect_clears_modes: assert property (@(posedge clock) disable iff (reset)
      effect_mode_ff != EFF_NONE |-> main_mode_ff == 2'd0 && colour_mode_ff == 3'd0)
      else $error("manual modes set while an effect runs");

   a_pulse_light_low: assert property (@(posedge clock) disable iff (reset)
      effect_mode_ff == EFF_NONE && ms_left_ff != '0 |-> !light_out_ff)
      else $error("main light on during its off pulse");

   a_held_item_waits: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_cmd_ff) && $stable(speed_ff))
      else $error("stalled item lost or state moved without a transfer");
`endif

endmodule

@@ bench/lamp_remote_mode_sequencer_core_tb.sv @@
module lamp_remote_mode_sequencer_core_tb;
   import lrms_pkg::*;

   localparam int unsigned FLASH_LEN = FLASH_MS_DEFAULT;
   localparam int unsigned PULSE_LEN = OFF_PULSE_MS_DEFAULT;

   typedef struct packed {
      logic red;
      logic green;
      logic blue;
      logic light;
   } drive_type;

   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              req_valid     = 1'b0;
   logic              req_op        = OP_TICK;
   logic [CODE_W-1:0] req_cmd_code  = '0;
   logic              rsp_ready     = 1'b0;
   logic              csr_valid     = 1'b0;
   logic [CSR_W-1:0]  csr_index     = CSR_CODE_OFF;
   logic [CODE_W-1:0] csr_wdata     = '0;
   logic              req_ready;
   logic              rsp_valid;
   logic              rsp_led_red;
   logic              rsp_led_green;
   logic              rsp_led_blue;
   logic              rsp_main_light;
   logic              csr_ready;

   // shadow of the block state
   logic [CODE_W-1:0]  code_reg [4];
   logic [1:0]         p_main_mode;
   logic [2:0]         p_colour_mode;
   logic [2:0]         p_effect;
   logic [SPEED_W-1:0] p_speed;
   logic [2:0]         p_rgb;
   logic               p_light;
   logic [MS_W-1:0]    p_ms_left;
   logic               p_phase;

   drive_type expected_drive_q [$];
   int     err_count = 0;
   bit     calm      = 1'b0;

   lamp_remote_mode_sequencer_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_cmd_code   (req_cmd_code),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_led_red    (rsp_led_red),
      .rsp_led_green  (rsp_led_green),
      .rsp_led_blue   (rsp_led_blue),
      .rsp_main_light (rsp_main_light),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 7);
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [MS_W-1:0] step_delay(input logic [SPEED_W-1:0] idx);
      logic [MS_W-1:0] d;
      case (idx)
         4'd0:    d = 10'd20;
         4'd1:    d = 10'd25;
         4'd2:    d = 10'd50;
         4'd3:    d = 10'd100;
         4'd4:    d = 10'd200;
         4'd5:    d = 10'd300;
         4'd6:    d = 10'd400;
         4'd7:    d = 10'd500;
         4'd8:    d = 10'd800;
         default: d = 10'd1000;
      endcase
      return d;
   endfunction

   function void lamp_reset();
      code_reg[CSR_CODE_OFF]    = CODE_OFF_RST;
      code_reg[CSR_CODE_EFFECT] = CODE_EFFECT_RST;
      code_reg[CSR_CODE_COLOUR] = CODE_COLOUR_RST;
      code_reg[CSR_CODE_MAIN]   = CODE_MAIN_RST;
      p_main_mode   = 2'd1;
      p_colour_mode = 3'd0;
      p_effect      = EFF_NONE;
      p_speed       = SPEED_RST;
      p_rgb         = RGB_OFF;
      p_light       = 1'b1;
      p_ms_left     = '0;
      p_phase       = 1'b0;
   endfunction

   // action of the current effect step, then load its wait
   function void lamp_load_step();
      logic first;
      first = (p_phase == 1'b0);
      case (p_effect)
         EFF_BLINK: begin
            p_rgb     = first ? RGB_ALL : RGB_OFF;
            p_ms_left = step_delay(p_speed);
         end
         EFF_COUNT: begin
            p_rgb     = (p_rgb < 3'd7) ? p_rgb + 3'd1 : 3'd1;
            p_ms_left = step_delay(p_speed);
         end
         EFF_TOGGLE: begin
            p_light   = ~p_light;
            p_ms_left = step_delay(p_speed);
         end
         EFF_BOTH: begin
            p_light   = ~p_light;
            p_rgb     = (p_rgb < 3'd7) ? p_rgb + 3'd1 : 3'd1;
            p_ms_left = step_delay(p_speed);
         end
         EFF_FL_RGB: begin
            p_rgb     = first ? RGB_ALL : RGB_OFF;
            p_ms_left = first ? MS_W'(FLASH_LEN) : step_delay(p_speed);
         end
         EFF_FL_MAIN: begin
            p_light   = first;
            p_ms_left = first ? MS_W'(FLASH_LEN) : step_delay(p_speed);
         end
         EFF_FL_ALL: begin
            p_rgb     = first ? RGB_ALL : RGB_OFF;
            p_light   = first;
            p_ms_left = first ? MS_W'(FLASH_LEN) : step_delay(p_speed);
         end
         default: begin
            p_ms_left = '0;
         end
      endcase
   endfunction

   function drive_type lamp_step(input logic op, input logic [CODE_W-1:0] code);
      drive_type d;
      if (op == OP_TICK) begin
         if (p_ms_left != '0) begin
            p_ms_left = p_ms_left - 1'b1;
            if (p_ms_left == '0) begin
               if (p_effect != EFF_NONE) begin
                  if (p_effect == EFF_BLINK || p_effect >= EFF_FL_RGB) p_phase = ~p_phase;
                  lamp_load_step();
               end else begin
                  p_light = (p_main_mode != 2'd0);
               end
            end
         end
      end else if (code == code_reg[CSR_CODE_OFF]) begin
         p_main_mode   = 2'd0;
         p_colour_mode = 3'd0;
         p_effect      = EFF_NONE;
         p_speed       = '0;
         p_rgb         = RGB_OFF;
         p_light       = 1'b0;
         p_ms_left     = '0;
         p_phase       = 1'b0;
      end else if (code == code_reg[CSR_CODE_EFFECT]) begin
         p_main_mode   = 2'd0;
         p_colour_mode = 3'd0;
         p_rgb         = RGB_OFF;
         p_light       = 1'b0;
         p_ms_left     = '0;
         p_phase       = 1'b0;
         p_effect      = p_effect + 3'd1;
         if (p_effect != EFF_NONE) lamp_load_step();
      end else if (code == code_reg[CSR_CODE_COLOUR]) begin
         if (p_effect != EFF_NONE) begin
            if (p_speed > '0) p_speed = p_speed - 1'b1;
         end else begin
            p_colour_mode = (p_colour_mode < 3'd4) ? p_colour_mode + 3'd1 : 3'd0;
            case (p_colour_mode)
               3'd1:    p_rgb = RGB_RED;
               3'd2:    p_rgb = RGB_GREEN;
               3'd3:    p_rgb = RGB_BLUE;
               3'd4:    p_rgb = RGB_ALL;
               default: p_rgb = RGB_OFF;
            endcase
         end
      end else if (code == code_reg[CSR_CODE_MAIN]) begin
         if (p_effect != EFF_NONE) begin
            if (p_speed < SPEED_MAX) p_speed = p_speed + 1'b1;
         end else begin
            p_main_mode = (p_main_mode < 2'd3) ? p_main_mode + 2'd1 : 2'd0;
            p_light     = 1'b0;
            p_ms_left   = MS_W'(PULSE_LEN);
         end
      end
      d.red   = p_rgb[2];
      d.green = p_rgb[1];
      d.blue  = p_rgb[0];
      d.light = p_light;
      return d;
   endfunction

   // one process sees every transfer, so the predictor and the checker stay in order
   always @(posedge clock) begin : xfer_watch
      drive_type want;
      if (reset) begin
         lamp_reset();
         expected_drive_q.delete();
      end else begin
         if (csr_valid && csr_ready) code_reg[csr_index] = csr_wdata;
         if (req_valid && req_ready) expected_drive_q.push_back(lamp_step(req_op, req_cmd_code));
         if (rsp_valid && rsp_ready) begin
            if (expected_drive_q.size() == 0) begin
               $error("response transfer with no expected drive levels");
               err_count++;
            end else begin
               want = expected_drive_q.pop_front();
               if (rsp_led_red !== want.red) begin
                  $error("led_red expected %0b actual %0b", want.red, rsp_led_red);
                  err_count++;
               end
               if (rsp_led_green !== want.green) begin
                  $error("led_green expected %0b actual %0b", want.green, rsp_led_green);
                  err_count++;
               end
               if (rsp_led_blue !== want.blue) begin
                  $error("led_blue expected %0b actual %0b", want.blue, rsp_led_blue);
                  err_count++;
               end
               if (rsp_main_light !== want.light) begin
                  $error("main_light expected %0b actual %0b", want.light, rsp_main_light);
                  err_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic send_item(input logic op, input logic [CODE_W-1:0] code);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(99) < 7) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_cmd_code <= code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_cmd(input logic [CODE_W-1:0] code);
      send_item(OP_CMD, code);
   endtask

   // ticks carry a random command byte that must be ignored
   task automatic send_ticks(input int n);
      for (int i = 0; i < n; i++) send_item(OP_TICK, CODE_W'($urandom_range(255)));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_drive_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_W-1:0] idx, input logic [CODE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // codes change only with nothing in flight
   task automatic set_codes(input logic [CODE_W-1:0] c_off, input logic [CODE_W-1:0] c_eff,
                            input logic [CODE_W-1:0] c_col, input logic [CODE_W-1:0] c_main);
      wait_idle();
      write_csr(CSR_CODE_OFF, c_off);
      write_csr(CSR_CODE_EFFECT, c_eff);
      write_csr(CSR_CODE_COLOUR, c_col);
      write_csr(CSR_CODE_MAIN, c_main);
   endtask

   function automatic logic [CODE_W-1:0] pick_cmd();
      int r;
      r = $urandom_range(99);
      if (r < 8) return code_reg[CSR_CODE_OFF];
      if (r < 33) return code_reg[CSR_CODE_EFFECT];
      if (r < 58) return code_reg[CSR_CODE_COLOUR];
      if (r < 85) return code_reg[CSR_CODE_MAIN];
      return CODE_W'($urandom_range(255));
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_basic_commands();
      send_item(OP_TICK, 8'hFF);
      send_item(OP_TICK, 8'h00);
      send_cmd(8'h00);
      send_cmd(8'hFF);
      // colour walks off, R, G, B, all and wraps
      repeat (5) send_cmd(code_reg[CSR_CODE_COLOUR]);
      send_cmd(code_reg[CSR_CODE_COLOUR]);
      // main pulse, with a colour step while the light is dropped
      send_cmd(code_reg[CSR_CODE_MAIN]);
      send_ticks(3);
      send_cmd(code_reg[CSR_CODE_COLOUR]);
      send_ticks(9);
      send_cmd(code_reg[CSR_CODE_MAIN]);
      send_ticks(11);
      send_cmd(code_reg[CSR_CODE_MAIN]);
      send_ticks(11);
      send_cmd(code_reg[CSR_CODE_MAIN]);
      send_ticks(11);
      // effect cancels a running pulse
      send_cmd(code_reg[CSR_CODE_MAIN]);
      send_ticks(4);
      send_cmd(code_reg[CSR_CODE_EFFECT]);
      send_ticks(15);
      send_cmd(code_reg[CSR_CODE_OFF]);
      send_ticks(2);
   endtask

   task automatic test_effect_walk();
      send_cmd(code_reg[CSR_CODE_OFF]);
      for (int k = 1; k <= 8; k++) begin
         send_cmd(code_reg[CSR_CODE_EFFECT]);
         send_ticks(6);
         // speed commands in the middle of a wait
         if (k == 2 || k == 6) send_cmd(code_reg[CSR_CODE_COLOUR]);
         if (k == 4 || k == 7) send_cmd(code_reg[CSR_CODE_MAIN]);
         send_ticks(18);
      end
      send_ticks(5);
   endtask

   task automatic test_speed_limits();
      send_cmd(code_reg[CSR_CODE_OFF]);
      // blink at the fastest speed
      send_cmd(code_reg[CSR_CODE_EFFECT]);
      // saturates at nine, then back down to one
      repeat (11) send_cmd(code_reg[CSR_CODE_MAIN]);
      repeat (8) send_cmd(code_reg[CSR_CODE_COLOUR]);
      send_ticks(20);
      send_ticks(26);
      // saturates at zero
      repeat (4) send_cmd(code_reg[CSR_CODE_COLOUR]);
      send_ticks(50);
      send_cmd(code_reg[CSR_CODE_OFF]);
   endtask

   task automatic test_code_priority();
      set_codes(8'hA5, 8'hA5, 8'hA5, 8'hA5);
      send_cmd(8'hA5);
      send_cmd(8'h5A);
      set_codes(8'h00, 8'hFF, 8'hFF, 8'hFF);
      send_cmd(8'hFF);
      send_ticks(25);
      send_cmd(8'hFF);
      send_ticks(25);
      send_cmd(8'h00);
      set_codes(8'h00, 8'h01, 8'hFF, 8'hFF);
      repeat (6) send_cmd(8'hFF);
      send_cmd(8'h01);
      send_ticks(3);
      wait_idle();
   endtask

   task automatic test_random(input int n_items, input bit calm_start);
      int sent;
      int run;
      int r;
      sent = 0;
      calm = calm_start;
      while (sent < n_items) begin
         if (calm && sent > (n_items * 2) / 3) calm = 1'b0;
         send_cmd(pick_cmd());
         sent++;
         r = $urandom_range(99);
         if (r < 80) run = $urandom_range(0, 20);
         else if (r < 97) run = $urandom_range(21, 60);
         else run = $urandom_range(61, 300);
         send_ticks(run);
         sent += run;
         if ($urandom_range(99) < 2) wait_idle();
      end
      calm = 1'b0;
      wait_idle();
   endtask

   initial begin
      logic [CODE_W-1:0] c [4];
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_commands();
      test_effect_walk();
      test_speed_limits();
      wait_idle();
      test_code_priority();

      set_codes(CODE_OFF_RST, CODE_EFFECT_RST, CODE_COLOUR_RST, CODE_MAIN_RST);
      test_random(90, 1'b1);

      for (int i = 0; i < 4; i++) c[i] = CODE_W'($urandom_range(255));
      set_codes(c[0], c[1], c[2], c[3]);
      test_random(90, 1'b0);

      set_codes(8'h00, 8'hFF, 8'h80, 8'h7F);
      test_random(90, 1'b0);

      if (expected_drive_q.size() != 0) begin
         $error("%0d expected responses never arrived", expected_drive_q.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/lrms_pkg.sv
rtl/lamp_remote_mode_sequencer_core.sv
bench/lamp_remote_mode_sequencer_core_tb.sv
